@@ sv/spc_pkg.sv @@
package spc_pkg;

	localparam int STEPS_PER_TURN = 2048;
	localparam int POS_W = $clog2(STEPS_PER_TURN);
	localparam int HALF_TURN = STEPS_PER_TURN / 2;
	localparam int COUNT_W = 8;

	// Depth of the queue between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [2:0] MODE_TICK      = 3'd0;
	localparam logic [2:0] MODE_STEP      = 3'd1;
	localparam logic [2:0] MODE_HOME      = 3'd2;
	localparam logic [2:0] MODE_ABS_SHORT = 3'd3;
	localparam logic [2:0] MODE_ABS_SLICE = 3'd4;
	localparam logic [2:0] MODE_REL       = 3'd5;

	typedef struct packed {
		logic [2:0]         mode;
		logic               direction;
		logic [10:0]        target;
		logic [COUNT_W-1:0] step_count;
		logic               limit_switch;
	} cmd_t;

	typedef struct packed {
		logic [3:0]  coil_pattern;
		logic [10:0] position;
		logic        busy_res;
		logic        stepped;
		logic        move_done;
		logic        homed;
	} res_t;

	typedef enum logic [2:0] {
		OP_TICK,
		OP_STEP,
		OP_HOME,
		OP_ABS,
		OP_REL,
		OP_NONE
	} op_t;

	// A classified word as it waits in the queue.
	typedef struct packed {
		op_t                op;
		logic               direction;
		logic               slice;
		logic [POS_W-1:0]   target;
		logic [COUNT_W-1:0] count;
		logic               pressed;
	} job_t;

	typedef enum logic [1:0] {
		KIND_IDLE,
		KIND_HOME,
		KIND_ABS,
		KIND_REL
	} kind_t;

endpackage

@@ sv/spc_front.sv @@
module spc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  spc_pkg::cmd_t cmd,
	output logic          job_valid,
	input  logic          job_take,
	output spc_pkg::job_t job
);
	import spc_pkg::*;

	job_t              job_in;
	job_t              job_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;

	always_comb begin
		job_in.direction = cmd.direction;
		job_in.slice     = (cmd.mode == MODE_ABS_SLICE);
		job_in.target    = POS_W'(cmd.target % STEPS_PER_TURN);
		job_in.count     = cmd.step_count;
		job_in.pressed   = ~cmd.limit_switch;
		unique case (cmd.mode) inside
			MODE_TICK:                      job_in.op = OP_TICK;
			MODE_STEP:                      job_in.op = OP_STEP;
			MODE_HOME:                      job_in.op = OP_HOME;
			MODE_ABS_SHORT, MODE_ABS_SLICE: job_in.op = OP_ABS;
			MODE_REL:                       job_in.op = OP_REL;
			default:                        job_in.op = OP_NONE;
		endcase
	end

	assign cmd_stall = (count_q == (QPTR_W+1)'(QDEPTH));
	assign job_valid = (count_q != '0);
	assign push      = cmd_valid && !cmd_stall;
	assign pop       = job_take && job_valid;
	assign job       = job_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			job_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/spc_back.sv @@
module spc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_take,
	input  spc_pkg::job_t job,
	output logic          res_valid,
	input  logic          res_stall,
	output spc_pkg::res_t res
);
	import spc_pkg::*;

	logic [1:0]         phase_q;
	logic [POS_W-1:0]   pos_q;
	kind_t              kind_q;
	logic               mdir_q;
	logic [POS_W-1:0]   goal_q;
	logic [COUNT_W-1:0] left_q;
	logic               last_q;
	logic               res_valid_q;
	res_t               res_q;

	kind_t              kind_d;
	logic [1:0]         phase_d;
	logic [POS_W-1:0]   pos_d;
	logic               mdir_d;
	logic [POS_W-1:0]   goal_d;
	logic [COUNT_W-1:0] left_d;
	logic               last_d;
	logic               stepped_d;
	logic               done_d;
	logic               homed_d;

	logic               step_dir;
	logic [1:0]         step_phase;
	logic [POS_W-1:0]   step_pos;
	logic [COUNT_W-1:0] left_dec;
	logic               home_hit;
	logic               abs_above;
	logic [POS_W-1:0]   dist_up;
	logic [POS_W-1:0]   dist_down;
	logic               abs_dir;
	logic               abs_here;

	assign job_take = job_valid && (!res_valid_q || !res_stall);

	// One step of the motor in the direction that a single-step word calls for, else in the direction of the current move.
	always_comb begin
		step_dir = (job.op == OP_STEP) ? job.direction : mdir_q;
		if (step_dir) begin
			step_phase = phase_q - 2'd1;
			step_pos   = (pos_q == '0) ? POS_W'(STEPS_PER_TURN - 1) : pos_q - 1'b1;
		end else begin
			step_phase = phase_q + 2'd1;
			step_pos   = ({1'b0, pos_q} + 1'b1 >= (POS_W+1)'(STEPS_PER_TURN)) ?
				'0 : pos_q + 1'b1;
		end
	end

	always_comb begin
		left_dec  = left_q - 1'b1;
		home_hit  = job.pressed && last_q;
		abs_above = (job.target > pos_q);
		abs_here  = (job.target == pos_q);
		dist_up   = job.target - pos_q;
		dist_down = pos_q - job.target;
		if (abs_above) begin
			abs_dir = job.slice ? 1'b0 :
				!({1'b0, dist_up} < (POS_W+1)'(HALF_TURN));
		end else begin
			abs_dir = job.slice ? 1'b1 :
				({1'b0, dist_down} < (POS_W+1)'(HALF_TURN));
		end
	end

	// Next move kind.
	always_comb begin
		kind_d = kind_q;
		unique case (job.op)
			OP_TICK: begin
				unique case (kind_q)
					KIND_HOME: if (home_hit) kind_d = KIND_IDLE;
					KIND_ABS:  if (step_pos == goal_q) kind_d = KIND_IDLE;
					KIND_REL:  if (left_dec == '0) kind_d = KIND_IDLE;
					default:   kind_d = KIND_IDLE;
				endcase
			end
			OP_STEP: kind_d = KIND_IDLE;
			OP_HOME: kind_d = KIND_HOME;
			OP_ABS:  kind_d = abs_here ? KIND_IDLE : KIND_ABS;
			OP_REL:  kind_d = (job.count == '0) ? KIND_IDLE : KIND_REL;
			default: kind_d = kind_q;
		endcase
	end

	// Datapath updates and result flags.
	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		mdir_d    = mdir_q;
		goal_d    = goal_q;
		left_d    = left_q;
		last_d    = last_q;
		stepped_d = 1'b0;
		done_d    = 1'b0;
		homed_d   = 1'b0;
		unique case (job.op)
			OP_TICK: begin
				unique case (kind_q)
					KIND_HOME: begin
						if (home_hit) begin
							pos_d   = '0;
							done_d  = 1'b1;
							homed_d = 1'b1;
						end else begin
							last_d    = job.pressed;
							phase_d   = step_phase;
							pos_d     = step_pos;
							stepped_d = 1'b1;
						end
					end
					KIND_ABS: begin
						phase_d   = step_phase;
						pos_d     = step_pos;
						stepped_d = 1'b1;
						done_d    = (step_pos == goal_q);
					end
					KIND_REL: begin
						phase_d   = step_phase;
						pos_d     = step_pos;
						stepped_d = 1'b1;
						left_d    = left_dec;
						done_d    = (left_dec == '0);
					end
					default: ;
				endcase
			end
			OP_STEP: begin
				phase_d   = step_phase;
				pos_d     = step_pos;
				stepped_d = 1'b1;
			end
			OP_HOME: begin
				mdir_d = job.direction;
				last_d = 1'b0;
			end
			OP_ABS: begin
				mdir_d = abs_dir;
				goal_d = job.target;
				done_d = abs_here;
			end
			OP_REL: begin
				mdir_d = job.direction;
				left_d = job.count;
				done_d = (job.count == '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			pos_q       <= '0;
			kind_q      <= KIND_IDLE;
			mdir_q      <= 1'b0;
			goal_q      <= '0;
			left_q      <= '0;
			last_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (job_take) begin
				phase_q     <= phase_d;
				pos_q       <= pos_d;
				kind_q      <= kind_d;
				mdir_q      <= mdir_d;
				goal_q      <= goal_d;
				left_q      <= left_d;
				last_q      <= last_d;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			res_q.coil_pattern <= 4'b0001 << phase_d;
			res_q.position     <= 11'(pos_d);
			res_q.busy_res     <= (kind_d != KIND_IDLE);
			res_q.stepped      <= stepped_d;
			res_q.move_done    <= done_d;
			res_q.homed        <= homed_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

@@ sv/stepper_position_controller.sv @@
// Four-phase wave-drive stepper controller. Each word on the cmd channel is either a step
// tick or a command (single step, homing, absolute move by shortest path or without wrap,
// relative move); each gives exactly one word on the res channel with the one-hot coil
// drive, the step position modulo one turn and the move status. A word is classified on
// entry and written into a four-entry queue, then the back end carries it out against the
// motor state and loads the result register, which holds it until the receiver takes it.
// The block sustains one word per clock while neither side stalls; the queue and the
// result register let either side stall without stopping the other.
module stepper_position_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  spc_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output spc_pkg::res_t res
);
	import spc_pkg::*;

	logic job_valid;
	logic job_take;
	job_t job;

	spc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.job_valid (job_valid),
		.job_take  (job_take),
		.job       (job)
	);

	spc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_take  (job_take),
		.job       (job),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
